// ----- sv/rtc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the RTC calendar tick block
// Calendar record layout, counter limits, reset values and month lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

  // default width of the free-running time counter
  localparam int unsigned DEF_COUNTER_WIDTH = 32;

  // payload widths on the stream ports
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CAL_W      = 45;

  // calendar record, least significant field last
  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rtc_time_t;

  // carry limits
  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [2:0] WDAY_LAST  = 3'd7;
  localparam logic [2:0] WDAY_FIRST = 3'd1;
  localparam logic [4:0] DAY_FIRST  = 5'd1;
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST = 4'd12;
  localparam logic [3:0] MONTH_FEB  = 4'd2;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

  // year modulo 400 tracking for the Gregorian rule
  localparam logic [8:0] Y400_LAST  = 9'd399;
  localparam logic [8:0] Y400_100   = 9'd100;
  localparam logic [8:0] Y400_200   = 9'd200;
  localparam logic [8:0] Y400_300   = 9'd300;
  localparam logic [8:0] Y400_RESET = 9'd10;     // 2010 mod 400
  localparam logic [15:0] YEAR_MAX  = 16'hFFFF;

  // calendar after reset: Friday 1 January 2010, 00:00:00
  localparam rtc_time_t RESET_CAL = '{
    year:    16'd2010,
    month:   4'd1,
    day:     5'd1,
    weekday: 3'd5,
    hour:    5'd0,
    minute:  6'd0,
    second:  6'd0
  };

  // length of a month in a common year
  function automatic logic [4:0] days_in_month(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rtc_base.sv -----
// ----------------------------------------------------------------------------
// rtc_base: counter base register and one-second detect
// Holds the base count, decides whether a poll advances one second and
// moves the base on capture or advance.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_base #(
  parameter int unsigned COUNTER_WIDTH = rtc_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        commit,     // item leaves the input register
  input  wire logic        op,         // 1 capture, 0 poll
  input  wire logic [31:0] counter_value,
  input  wire logic [23:0] ticks_per_second,
  output logic             advance
);
  import rtc_pkg::*;

  logic [COUNTER_WIDTH-1:0] base;
  logic [COUNTER_WIDTH-1:0] base_next;
  logic [COUNTER_WIDTH-1:0] cnt;
  logic [COUNTER_WIDTH-1:0] elapsed;
  logic [32:0]              sum;

  // elapsed count modulo the counter width, strict compare to one second
  always_comb begin
    cnt     = counter_value[COUNTER_WIDTH-1:0];
    elapsed = cnt - base;
    advance = !op && (33'(elapsed) > 33'(ticks_per_second));
    sum     = 33'(base) + 33'(ticks_per_second);
    if (op) begin
      base_next = cnt;
    end else if (advance) begin
      base_next = sum[COUNTER_WIDTH-1:0];
    end else begin
      base_next = base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (commit) begin
      base <= base_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rtc_cal.sv -----
// ----------------------------------------------------------------------------
// rtc_cal: calendar counters
// Second, minute, hour, weekday, day, month and year with Gregorian leap
// years; advances by one second per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_cal (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         tick,
  output rtc_pkg::rtc_time_t cal_next
);
  import rtc_pkg::*;

  rtc_time_t  cal;
  logic [8:0] y400;        // year modulo 400, forced to 0 on 16-bit wrap
  logic [8:0] y400_next;
  logic       leap;
  logic [4:0] month_len;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       month_wrap;

  // carry conditions
  always_comb begin
    leap = (y400 == '0) ||
           ((y400[1:0] == 2'b00) && (y400 != Y400_100) &&
            (y400 != Y400_200) && (y400 != Y400_300));
    month_len  = (cal.month == MONTH_FEB && leap) ? DAYS_FEB_LEAP
                                                  : days_in_month(cal.month);
    sec_wrap   = cal.second >= SEC_LAST;
    min_wrap   = cal.minute >= MIN_LAST;
    hour_wrap  = cal.hour >= HOUR_LAST;
    day_wrap   = cal.day >= month_len;
    month_wrap = cal.month >= MONTH_LAST;
  end

  // one-second advance with ripple of carries
  always_comb begin
    cal_next  = cal;
    y400_next = y400;
    if (tick) begin
      if (!sec_wrap) begin
        cal_next.second = cal.second + 6'd1;
      end else begin
        cal_next.second = '0;
        if (!min_wrap) begin
          cal_next.minute = cal.minute + 6'd1;
        end else begin
          cal_next.minute = '0;
          if (!hour_wrap) begin
            cal_next.hour = cal.hour + 5'd1;
          end else begin
            cal_next.hour    = '0;
            cal_next.weekday = (cal.weekday == WDAY_LAST) ? WDAY_FIRST
                                                          : cal.weekday + 3'd1;
            if (!day_wrap) begin
              cal_next.day = cal.day + 5'd1;
            end else begin
              cal_next.day = DAY_FIRST;
              if (!month_wrap) begin
                cal_next.month = cal.month + 4'd1;
              end else begin
                cal_next.month = MONTH_FIRST;
                cal_next.year  = cal.year + 16'd1;
                y400_next = (cal.year == YEAR_MAX || y400 == Y400_LAST) ? '0
                                                                        : y400 + 9'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cal  <= RESET_CAL;
      y400 <= Y400_RESET;
    end else begin
      cal  <= cal_next;
      y400 <= y400_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rtc_calendar_tick.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_tick: calendar clock updated by polls of a time counter
// Input register, base and calendar update, result register.
// ----------------------------------------------------------------------------
// Every input word yields exactly one result word. A capture word (tuser 1)
// loads the counter value as the base; a poll word (tuser 0) advances the
// calendar by one second when the elapsed count since the base exceeds
// ticks_per_second, and then moves the base on by ticks_per_second. The
// result always shows the calendar after the word. A word is registered in the
// input register when it is accepted, and its result is registered in the result
// register when the result side can take it, and one word is taken every cycle
// while the result side keeps up: the base compare and the full carry chain of the
// calendar settle combinationally between the input register and the result
// register. While a finished word waits downstream, the input register can still
// take one word if it is empty.
`default_nettype none

module rtc_calendar_tick #(
  parameter int unsigned COUNTER_WIDTH = rtc_pkg::DEF_COUNTER_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rtc_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // counter_value[31:0],
                                                             // ticks_per_second[55:32]
  input  wire logic                           s_axis_tuser,  // op: 1 capture, 0 poll
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [rtc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // second, minute, hour, weekday,
                                                             // day_of_month, month_now,
                                                             // year_now, pad
  output logic                                m_axis_tuser   // advanced
);
  import rtc_pkg::*;

  logic        in_vld;
  logic        in_op;
  logic [31:0] in_cnt;
  logic [23:0] in_tps;
  logic        out_take;
  logic        commit;
  logic        advance;
  rtc_time_t   cal_next;

  // pipeline handshake
  assign out_take      = !m_axis_tvalid || m_axis_tready;
  assign commit        = in_vld && out_take;
  assign s_axis_tready = !in_vld || out_take;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld <= s_axis_tvalid;
      end
      if (out_take) begin
        m_axis_tvalid <= in_vld;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op  <= s_axis_tuser;
      in_cnt <= s_axis_tdata[31:0];
      in_tps <= s_axis_tdata[55:32];
    end
  end

  rtc_base #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_base (
    .clk              (clk),
    .rst              (rst),
    .commit           (commit),
    .op               (in_op),
    .counter_value    (in_cnt),
    .ticks_per_second (in_tps),
    .advance          (advance)
  );

  rtc_cal u_cal (
    .clk      (clk),
    .rst      (rst),
    .tick     (commit && advance),
    .cal_next (cal_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tuser <= advance;
      m_axis_tdata <= {3'b000, cal_next};
    end
  end

endmodule

`default_nettype wire

// ----- sv/rtc_checker.sv -----
// ----------------------------------------------------------------------------
// rtc_checker: port-level checks of the RTC calendar tick block
// Result stability, calendar field ranges and word-to-word consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [rtc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);
  import rtc_pkg::*;

  rtc_time_t out_cal;
  rtc_time_t prev_cal;    // calendar of the last delivered word
  logic      out_fire;

  assign out_cal  = m_axis_tdata[CAL_W-1:0];
  assign out_fire = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cal <= RESET_CAL;
    end else if (out_fire) begin
      prev_cal <= out_cal;
    end
  end

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // calendar fields stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_cal.second <= SEC_LAST && out_cal.minute <= MIN_LAST &&
                      out_cal.hour <= HOUR_LAST && out_cal.weekday != '0 &&
                      out_cal.day != '0 && out_cal.month != '0 &&
                      out_cal.month <= MONTH_LAST)
    else $error("calendar field out of range");

  // no advance, no change
  a_still: assert property (@(posedge clk) disable iff (rst)
    out_fire && !m_axis_tuser |-> out_cal == prev_cal)
    else $error("calendar moved without advance");

  // advance always moves the calendar
  a_moved: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_axis_tuser |-> out_cal != prev_cal)
    else $error("advance flagged but calendar unchanged");

  // reset empties the pipe and opens the input side
  a_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("pipe not empty after reset");

endmodule

bind rtc_calendar_tick rtc_checker u_rtc_checker (.*);

`default_nettype wire
